// ===== hdl/pob_pkg.sv =====
package pob_pkg;

  // field widths of one request and one result
  localparam int unsigned ActionW = 3;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned DurW    = 16;
  localparam int unsigned ViewW   = 8;

  // defaults for the top level parameters
  localparam int unsigned NumOutputsDef = 8;
  localparam int unsigned CountBitsDef  = 16;

  typedef enum logic [ActionW-1:0] {
    ActTick   = 3'd0,
    ActSet    = 3'd1,
    ActGet    = 3'd2,
    ActToggle = 3'd3,
    ActPulse  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StTick   = 3'b010,
    StResult = 3'b100
  } state_e;

endpackage

// ===== hdl/pob_if.sv =====
// request channel: one action per request
interface pob_req_if import pob_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [ChanW-1:0]   channel;
  logic               level;
  logic [DurW-1:0]    duration;

  modport source (output valid, action, channel, level, duration, input ready);
  modport sink   (input valid, action, channel, level, duration, output ready);
endinterface

// result channel: state of the bank after the action
interface pob_rsp_if import pob_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             read_level;
  logic [ViewW-1:0] pin_levels;
  logic [ViewW-1:0] pulses_active;

  modport source (output valid, read_level, pin_levels, pulses_active, input ready);
  modport sink   (input valid, read_level, pin_levels, pulses_active, output ready);
endinterface

// ===== hdl/pulse_output_bank_unit.sv =====
// Bank of NUM_OUTPUTS output pins, each with a polarity invert bit (invert mask,
// written through cfg_we_i / cfg_wdata_i) and a one-shot pulse countdown of
// COUNT_BITS bits held in a small RAM. Every request yields one result holding
// the logical level of the addressed channel and the pin and countdown-active
// views of channels 0..7. Set, get, toggle and pulse requests go from idle to
// the result step and back to idle, where the next request is accepted; a tick
// first walks the counter RAM one channel per cycle through its single read
// port and writes each decremented value back in the next cycle. A nonzero flag
// per channel in flip-flops marks the live counters, so the RAM needs no
// clearing after reset. A result waiting in the output register does not
// stop the next request from being accepted.
module pulse_output_bank_unit import pob_pkg::*; #(
  parameter int unsigned NUM_OUTPUTS = NumOutputsDef,
  parameter int unsigned COUNT_BITS  = CountBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pob_req_if.sink          req_i,
  pob_rsp_if.source        rsp_o,
  input  logic             cfg_we_i,
  input  logic [ViewW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW   = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int unsigned WalkW  = $clog2(NUM_OUTPUTS + 1);
  localparam int unsigned ExtW   = (NUM_OUTPUTS > ViewW) ? NUM_OUTPUTS : ViewW;
  localparam int unsigned SatW   = (COUNT_BITS > DurW) ? COUNT_BITS : DurW;

  state_e                 state_q, state_d;
  logic [WalkW-1:0]       walk_q, walk_d;
  logic                   rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]        rd_idx_q, rd_idx_d;
  logic [ChanW-1:0]       ch_q, ch_d;
  logic [NUM_OUTPUTS-1:0] pin_q, pin_d;
  logic [NUM_OUTPUTS-1:0] nz_q, nz_d;
  logic [ViewW-1:0]       inv_q;
  logic                   out_vld_q, out_vld_d;
  logic                   out_rl_q;
  logic [ViewW-1:0]       out_pin_q, out_act_q;

  logic                  ram_we, ram_re;
  logic [IdxW-1:0]       ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata, dec_cnt, sat_cnt;
  logic [SatW-1:0]       dur_ext;

  logic             accept, out_load;
  logic             in_present, res_present, res_level;
  logic [IdxW-1:0]  in_idx, res_idx, walk_idx;
  logic [ExtW-1:0]  pin_ext, act_ext;

  pob_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_OUTPUTS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // request decode
  assign accept     = req_i.valid && req_i.ready;
  assign in_present = 32'(req_i.channel) < NUM_OUTPUTS;
  assign in_idx     = IdxW'(req_i.channel);
  assign walk_idx   = walk_q[IdxW-1:0];
  assign dec_cnt    = ram_rdata - COUNT_BITS'(1);

  // pulse length, saturated to the counter range
  assign dur_ext = SatW'(req_i.duration);
  assign sat_cnt = (dur_ext > SatW'({COUNT_BITS{1'b1}})) ? {COUNT_BITS{1'b1}}
                                                         : COUNT_BITS'(dur_ext);

  assign req_i.ready = (state_q == StIdle);

  // sequencer: actions, tick walk and result hand-off
  always_comb begin
    state_d   = state_q;
    walk_d    = walk_q;
    rd_vld_d  = rd_vld_q;
    rd_idx_d  = rd_idx_q;
    ch_d      = ch_q;
    pin_d     = pin_q;
    nz_d      = nz_q;
    ram_we    = 1'b0;
    ram_waddr = rd_idx_q;
    ram_wdata = dec_cnt;
    ram_re    = 1'b0;
    ram_raddr = walk_idx;
    out_load  = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          ch_d = req_i.channel;
          if (req_i.action == ActTick) begin
            state_d  = StTick;
            walk_d   = '0;
            rd_vld_d = 1'b0;
          end else begin
            state_d = StResult;
            if (in_present) begin
              case (req_i.action)
                ActSet: begin
                  pin_d[in_idx] = req_i.level ^ inv_q[req_i.channel];
                end
                ActToggle: begin
                  pin_d[in_idx] = ~pin_q[in_idx];
                end
                ActPulse: begin
                  if (!nz_q[in_idx]) begin
                    pin_d[in_idx] = ~pin_q[in_idx];
                  end
                  ram_we        = 1'b1;
                  ram_waddr     = in_idx;
                  ram_wdata     = sat_cnt;
                  nz_d[in_idx]  = (req_i.duration != '0);
                end
                default: begin
                end
              endcase
            end
          end
        end
      end
      StTick: begin
        // write back the counter read in the previous cycle
        if (rd_vld_q) begin
          ram_we = 1'b1;
          if (dec_cnt == '0) begin
            nz_d[rd_idx_q]  = 1'b0;
            pin_d[rd_idx_q] = ~pin_q[rd_idx_q];
          end
        end
        // read the next live counter
        if (walk_q < WalkW'(NUM_OUTPUTS)) begin
          ram_re   = nz_q[walk_idx];
          rd_vld_d = nz_q[walk_idx];
          rd_idx_d = walk_idx;
          walk_d   = walk_q + WalkW'(1);
        end else begin
          rd_vld_d = 1'b0;
          state_d  = StResult;
        end
      end
      StResult: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // result fields from the updated state
  assign res_present = 32'(ch_q) < NUM_OUTPUTS;
  assign res_idx     = IdxW'(ch_q);
  assign res_level   = res_present ? (pin_q[res_idx] ^ inv_q[ch_q]) : 1'b0;
  assign pin_ext     = ExtW'(pin_q);
  assign act_ext     = ExtW'(nz_q);

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // control and bank state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      walk_q    <= '0;
      rd_vld_q  <= 1'b0;
      pin_q     <= '0;
      nz_q      <= '0;
      inv_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      walk_q    <= walk_d;
      rd_vld_q  <= rd_vld_d;
      pin_q     <= pin_d;
      nz_q      <= nz_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        inv_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    ch_q     <= ch_d;
    if (out_load) begin
      out_rl_q  <= res_level;
      out_pin_q <= pin_ext[ViewW-1:0];
      out_act_q <= act_ext[ViewW-1:0];
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.read_level    = out_rl_q;
  assign rsp_o.pin_levels    = out_pin_q;
  assign rsp_o.pulses_active = out_act_q;

  // write-back and next read never hit the same counter
  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("counter write and read collide");

  // a nonzero pulse on a present channel marks its counter live
  a_pulse_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.action == ActPulse && in_present && req_i.duration != '0)
      |=> nz_q[$past(in_idx)])
    else $error("pulse did not mark counter live");

  // a result only appears after the sequencer reaches its result step
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == StResult))
    else $error("result raised outside result step");

  // no request is taken while a tick walk runs
  a_tick_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTick) |-> !req_i.ready)
    else $error("request accepted during tick walk");

endmodule

// ===== hdl/pob_ram.sv =====
module pob_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/pulse_output_bank_unit_test.sv =====
`timescale 1ns / 100ps

module pulse_output_bank_unit_test;
  import pob_pkg::*;

  localparam int unsigned ClkHalf      = 10;
  localparam int unsigned ResetCycles  = 6;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned MaskPhases   = 6;
  localparam int unsigned PhaseItems   = 230;
  localparam int unsigned SettleCycles = NumOutputsDef + 8;
  localparam int unsigned DirectedRows = 23;

  // action codes with no meaning in the bank
  localparam logic [ActionW-1:0] ActSpareA = 3'd5;
  localparam logic [ActionW-1:0] ActSpareB = 3'd6;
  localparam logic [ActionW-1:0] ActSpareC = 3'd7;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [ChanW-1:0]   channel;
    logic               level;
    logic [DurW-1:0]    duration;
  } request_t;

  typedef struct packed {
    logic             read_level;
    logic [ViewW-1:0] pin_levels;
    logic [ViewW-1:0] pulses_active;
  } view_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    view_t    view;
  } row_t;

  typedef struct packed {
    logic  typed;
    view_t view;
  } note_t;

  localparam view_t NoView = '0;

  // directed requests, invert mask still at its reset value
  localparam row_t Directed [DirectedRows] = '{
    '{'{ActGet,    3'd0, 1'b0, 16'h0000}, 1'b1, '{1'b0, 8'h00, 8'h00}},
    '{'{ActSet,    3'd7, 1'b1, 16'h0000}, 1'b1, '{1'b1, 8'h80, 8'h00}},
    '{'{ActSet,    3'd0, 1'b1, 16'h0000}, 1'b1, '{1'b1, 8'h81, 8'h00}},
    '{'{ActToggle, 3'd7, 1'b0, 16'h0000}, 1'b1, '{1'b0, 8'h01, 8'h00}},
    '{'{ActPulse,  3'd3, 1'b0, 16'hffff}, 1'b1, '{1'b1, 8'h09, 8'h08}},
    '{'{ActPulse,  3'd3, 1'b0, 16'h0002}, 1'b0, NoView},
    '{'{ActTick,   3'd3, 1'b0, 16'h0000}, 1'b0, NoView},
    '{'{ActTick,   3'd3, 1'b0, 16'h0000}, 1'b0, NoView},
    '{'{ActPulse,  3'd5, 1'b0, 16'h0000}, 1'b1, '{1'b1, 8'h21, 8'h00}},
    '{'{ActPulse,  3'd5, 1'b0, 16'h0001}, 1'b0, NoView},
    '{'{ActSpareA, 3'd5, 1'b1, 16'hffff}, 1'b1, '{1'b0, 8'h01, 8'h20}},
    '{'{ActSpareB, 3'd0, 1'b0, 16'h0000}, 1'b1, '{1'b1, 8'h01, 8'h20}},
    '{'{ActSpareC, 3'd7, 1'b1, 16'hffff}, 1'b1, '{1'b0, 8'h01, 8'h20}},
    '{'{ActTick,   3'd5, 1'b0, 16'h0000}, 1'b0, NoView},
    '{'{ActTick,   3'd0, 1'b0, 16'h0000}, 1'b0, NoView},
    '{'{ActPulse,  3'd0, 1'b0, 16'h0001}, 1'b0, NoView},
    '{'{ActPulse,  3'd1, 1'b0, 16'h0003}, 1'b0, NoView},
    '{'{ActTick,   3'd0, 1'b0, 16'h0000}, 1'b0, NoView},
    '{'{ActToggle, 3'd1, 1'b0, 16'h0000}, 1'b0, NoView},
    '{'{ActSet,    3'd1, 1'b0, 16'h0000}, 1'b0, NoView},
    '{'{ActGet,    3'd1, 1'b0, 16'h0000}, 1'b0, NoView},
    '{'{ActSet,    3'd2, 1'b1, 16'hffff}, 1'b0, NoView},
    '{'{ActGet,    3'd7, 1'b1, 16'hffff}, 1'b0, NoView}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [ViewW-1:0] cfg_wdata = '0;

  pob_req_if req_if ();
  pob_rsp_if rsp_if ();

  pulse_output_bank_unit #(
    .NUM_OUTPUTS(NumOutputsDef),
    .COUNT_BITS (CountBitsDef)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #ClkHalf clk = ~clk;

  // shadow copy of the bank
  logic [ViewW-1:0]         invert_bits;
  logic [NumOutputsDef-1:0] pin_state;
  logic [CountBitsDef-1:0]  countdown [NumOutputsDef];

  view_t       pending_views [$];
  note_t       request_notes [$];
  int unsigned mismatches;
  int unsigned requests_seen;
  int unsigned results_seen;
  int unsigned expiries_seen;
  int unsigned mask_settings;
  bit          no_idle;

  // apply one request to the shadow bank and return the view after it
  function automatic view_t apply_request(request_t r);
    view_t v;
    for (int i = 0; i < NumOutputsDef; i++) begin
      if (r.action == ActTick && countdown[i] != '0) begin
        countdown[i] = countdown[i] - 1'b1;
        if (countdown[i] == '0) begin
          pin_state[i] = ~pin_state[i];
          expiries_seen++;
        end
      end
    end
    case (r.action)
      ActSet: begin
        pin_state[r.channel] = r.level ^ invert_bits[r.channel];
      end
      ActToggle: begin
        pin_state[r.channel] = ~pin_state[r.channel];
      end
      ActPulse: begin
        // a running countdown is reloaded without touching the pin
        if (countdown[r.channel] == '0) pin_state[r.channel] = ~pin_state[r.channel];
        countdown[r.channel] = r.duration;
      end
      default: ;
    endcase
    v.read_level = pin_state[r.channel] ^ invert_bits[r.channel];
    v.pin_levels = pin_state[ViewW-1:0];
    for (int i = 0; i < ViewW; i++) v.pulses_active[i] = (countdown[i] != '0);
    return v;
  endfunction

  // mostly no gap, sometimes a few cycles, rarely a long one
  function automatic int unsigned idle_length();
    int unsigned pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random request, weighted toward pulses with short countdowns and ticks
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.channel  = ChanW'($urandom_range(0, NumOutputsDef - 1));
    r.level    = 1'($urandom_range(0, 1));
    r.duration = DurW'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 35) r.action = ActTick;
    else if (pick < 55) r.action = ActPulse;
    else if (pick < 70) r.action = ActSet;
    else if (pick < 80) r.action = ActGet;
    else if (pick < 92) r.action = ActToggle;
    else r.action = ActionW'($urandom_range(ActSpareA, ActSpareC));
    if (r.action == ActPulse) begin
      pick = $urandom_range(0, 15);
      if (pick == 1) r.duration = '0;
      else if (pick != 0) r.duration = DurW'($urandom_range(1, 6));
    end
    return r;
  endfunction

  task automatic send_request(request_t r, logic typed, view_t v);
    int unsigned gap;
    gap = idle_length();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_notes.push_back('{typed, v});
    req_if.valid    <= 1'b1;
    req_if.action   <= r.action;
    req_if.channel  <= r.channel;
    req_if.level    <= r.level;
    req_if.duration <= r.duration;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // only called with the bank idle
  task automatic write_invert_mask(logic [ViewW-1:0] mask);
    cfg_we      <= 1'b1;
    cfg_wdata   <= mask;
    invert_bits = mask;
    mask_settings++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result check first, then prediction for a newly accepted request
  always @(posedge clk) begin
    view_t got;
    view_t want;
    view_t predicted;
    note_t note;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.read_level, rsp_if.pin_levels, rsp_if.pulses_active};
        results_seen++;
        if (pending_views.size() == 0) begin
          $error("result with no request pending: pin_levels %h", got.pin_levels);
          mismatches++;
        end else begin
          want = pending_views.pop_front();
          if (got.read_level !== want.read_level) begin
            $error("read_level: expected %0d, got %0d", want.read_level, got.read_level);
            mismatches++;
          end
          if (got.pin_levels !== want.pin_levels) begin
            $error("pin_levels: expected %h, got %h", want.pin_levels, got.pin_levels);
            mismatches++;
          end
          if (got.pulses_active !== want.pulses_active) begin
            $error("pulses_active: expected %h, got %h", want.pulses_active,
                   got.pulses_active);
            mismatches++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        predicted = apply_request('{req_if.action, req_if.channel, req_if.level,
                                    req_if.duration});
        note = request_notes.pop_front();
        pending_views.push_back(note.typed ? note.view : predicted);
        requests_seen++;
      end
    end
  end

  // result side stalls
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_length();
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout after %0d quiet cycles", IdleLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus
  initial begin
    logic [ViewW-1:0] mask;
    req_if.valid    = 1'b0;
    req_if.action   = ActTick;
    req_if.channel  = '0;
    req_if.level    = 1'b0;
    req_if.duration = '0;
    invert_bits     = '0;
    pin_state       = '0;
    for (int i = 0; i < NumOutputsDef; i++) countdown[i] = '0;
    mismatches      = 0;
    requests_seen   = 0;
    results_seen    = 0;
    expiries_seen   = 0;
    mask_settings   = 0;
    no_idle         = 1'b0;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < DirectedRows; k++)
      send_request(Directed[k].req, Directed[k].typed, Directed[k].view);

    // random traffic under several invert masks, extremes first
    for (int p = 0; p < MaskPhases; p++) begin
      wait_for_results();
      if (p == 0) mask = '1;
      else if (p == 1) mask = '0;
      else mask = ViewW'($urandom_range(0, 255));
      write_invert_mask(mask);
      no_idle = (p == 2);
      for (int k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(0, 99) == 0) wait_for_results();
        send_request(random_request(), 1'b0, NoView);
      end
    end

    wait_for_results();
    repeat (SettleCycles) @(posedge clk);
    $display("ran %0d requests and %0d results over %0d invert mask settings",
             requests_seen, results_seen, mask_settings);
    $display("%0d countdowns ran out on a tick", expiries_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
